/* rtl/core/vibe_pkg.sv */
// Package for the background subtractor: payload structs, mode codes, sizes.
// No dependencies; used by every module in rtl/core.
`default_nettype none
package vibe_pkg;

  localparam int MaxRows   = 128;
  localparam int MaxCols   = 128;
  localparam int Samples   = 16;
  localparam int RowW      = $clog2(MaxRows);
  localparam int ColW      = $clog2(MaxCols);
  localparam int SlotW     = $clog2(Samples);
  localparam int AddrW     = RowW + ColW + SlotW;
  localparam int CntW      = $clog2(Samples + 1);

  localparam logic [1:0] CfgThresh = 2'd0;
  localparam logic [1:0] CfgMinClose = 2'd1;
  localparam logic [1:0] CfgRows = 2'd2;
  localparam logic [1:0] CfgCols = 2'd3;

  typedef enum logic [1:0] {
    MODE_CLASSIFY = 2'd0,
    MODE_UPDATE   = 2'd1,
    MODE_INIT     = 2'd2,
    MODE_NONE     = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_WR_NB, ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [6:0]  row;
    logic [6:0]  col;
    logic [7:0]  chan0;
    logic [7:0]  chan1;
    logic [7:0]  chan2;
    logic [3:0]  sample_slot;
    logic [2:0]  neighbor_dir;
    logic [7:0]  update_draw;
    logic        mask_foreground;
    logic [14:0] noise_packed;
  } in_item_t;

  typedef struct packed {
    logic       is_foreground;
    logic [4:0] close_count;
  } out_item_t;

  // Memory request from the sequencer.
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    logic [23:0]      wdata;
  } mem_req_t;

  // Saturating add of a 5-bit two's complement offset.
  function automatic logic [7:0] add_off(input logic [7:0] v, input logic [4:0] o);
    logic signed [9:0] s;
    s = $signed({2'b00, v}) + $signed({{5{o[4]}}, o});
    if (s < 0) return 8'd0;
    if (s > 10'sd255) return 8'hFF;
    return s[7:0];
  endfunction

  function automatic logic [7:0] absd(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage
`default_nettype wire

/* rtl/core/vibe_sample_mem.sv */
// Single-port sample memory with a registered read.
// Depends on vibe_pkg.
`default_nettype none
module vibe_sample_mem (
  input  wire logic              clk,
  input  wire vibe_pkg::mem_req_t req,
  output logic [23:0]            rdata
);
  logic [23:0] mem [0:(1 << vibe_pkg::AddrW) - 1];

  // Write or read one entry per cycle
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end
endmodule
`default_nettype wire

/* rtl/core/vibe_seq.sv */
// Sequencer: address generation, distance/count, update and init writes.
// Depends on vibe_pkg; drives vibe_sample_mem.
`default_nettype none
module vibe_seq (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire vibe_pkg::in_item_t in_item,
  input  wire logic [7:0]         thresh,
  input  wire logic [4:0]         min_close,
  input  wire logic [7:0]         rows,
  input  wire logic [7:0]         cols,
  input  wire logic [23:0]        rdata,
  output vibe_pkg::mem_req_t      req,
  output logic                    busy,
  output logic                    out_strobe,
  output vibe_pkg::out_item_t     out_item
);
  localparam int RowW = vibe_pkg::RowW;
  localparam int ColW = vibe_pkg::ColW;
  localparam int SlotW = vibe_pkg::SlotW;
  localparam int CntW = vibe_pkg::CntW;

  vibe_pkg::state_t state_r, state_nxt;
  vibe_pkg::in_item_t item_r;
  logic [RowW-1:0] r_r, nr_r;
  logic [ColW-1:0] c_r, nc_r;
  logic [SlotW:0] k_r;
  logic           rv_r;
  logic [CntW-1:0] cnt_r;
  logic           fg_r, strobe_r;

  // Clamp dimensions, position and the neighbour position
  logic [7:0] nrows, ncols;
  logic [RowW-1:0] r_in, nb_r;
  logic [ColW-1:0] c_in, nb_c;
  logic signed [RowW+1:0] tr;
  logic signed [ColW+1:0] tc;
  logic signed [1:0] dr, dc;
  always_comb begin
    nrows = (rows == 8'd0) ? 8'd1 : (rows > 8'(vibe_pkg::MaxRows)) ? 8'(vibe_pkg::MaxRows) : rows;
    ncols = (cols == 8'd0) ? 8'd1 : (cols > 8'(vibe_pkg::MaxCols)) ? 8'(vibe_pkg::MaxCols) : cols;
    r_in = ({1'b0, in_item.row} >= nrows) ? RowW'(nrows - 8'd1) : in_item.row;
    c_in = ({1'b0, in_item.col} >= ncols) ? ColW'(ncols - 8'd1) : in_item.col;
    case (in_item.neighbor_dir)
      3'd0: begin dr = -2'sd1; dc = -2'sd1; end
      3'd1: begin dr = -2'sd1; dc = 2'sd0; end
      3'd2: begin dr = -2'sd1; dc = 2'sd1; end
      3'd3: begin dr = 2'sd0; dc = -2'sd1; end
      3'd4: begin dr = 2'sd0; dc = 2'sd1; end
      3'd5: begin dr = 2'sd1; dc = -2'sd1; end
      3'd6: begin dr = 2'sd1; dc = 2'sd0; end
      default: begin dr = 2'sd1; dc = 2'sd1; end
    endcase
    tr = $signed({2'b00, r_in}) + (RowW+2)'(dr);
    tc = $signed({2'b00, c_in}) + (ColW+2)'(dc);
    if (tr < 0) nb_r = '0;
    else if (tr >= $signed({1'b0, nrows})) nb_r = RowW'(nrows - 8'd1);
    else nb_r = tr[RowW-1:0];
    if (tc < 0) nb_c = '0;
    else if (tc >= $signed({1'b0, ncols})) nb_c = ColW'(ncols - 8'd1);
    else nb_c = tc[ColW-1:0];
  end

  // Distance of the returned sample
  logic [8:0] d01, d012;
  logic [7:0] d;
  logic       close;
  always_comb begin
    d01 = {1'b0, vibe_pkg::absd(item_r.chan0, rdata[7:0])}
        + {1'b0, vibe_pkg::absd(item_r.chan1, rdata[15:8])};
    d = d01[8] ? 8'hFF : d01[7:0];
    d012 = {1'b0, d} + {1'b0, vibe_pkg::absd(item_r.chan2, rdata[23:16])};
    d = d012[8] ? 8'hFF : d012[7:0];
    close = d < thresh;
  end

  logic do_upd;
  assign do_upd = (in_item.update_draw == 8'd0) && !in_item.mask_foreground;
  logic [23:0] pix, ipix;
  assign pix = {in_item.chan2, in_item.chan1, in_item.chan0};
  assign ipix = {vibe_pkg::add_off(in_item.chan2, in_item.noise_packed[14:10]),
                 vibe_pkg::add_off(in_item.chan1, in_item.noise_packed[9:5]),
                 vibe_pkg::add_off(in_item.chan0, in_item.noise_packed[4:0])};

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vibe_pkg::ST_IDLE: begin
        if (start) begin
          if (in_item.mode == vibe_pkg::MODE_CLASSIFY) state_nxt = vibe_pkg::ST_READ;
          else if (in_item.mode == vibe_pkg::MODE_UPDATE && do_upd)
            state_nxt = vibe_pkg::ST_WR_NB;
          else state_nxt = vibe_pkg::ST_DONE;
        end
      end
      vibe_pkg::ST_READ:  if (rv_r && k_r == (SlotW+1)'(vibe_pkg::Samples)) state_nxt = vibe_pkg::ST_DONE;
      vibe_pkg::ST_WR_NB: state_nxt = vibe_pkg::ST_DONE;
      vibe_pkg::ST_DONE:  state_nxt = vibe_pkg::ST_IDLE;
      default:            state_nxt = vibe_pkg::ST_IDLE;
    endcase
  end

  // Memory request
  always_comb begin
    req = '0;
    case (state_r)
      vibe_pkg::ST_IDLE: begin
        req.addr = {r_in, c_in, in_item.sample_slot};
        if (start && in_item.mode == vibe_pkg::MODE_INIT) begin
          req.we = 1'b1; req.wdata = ipix;
        end else if (start && in_item.mode == vibe_pkg::MODE_UPDATE && do_upd) begin
          req.we = 1'b1; req.wdata = pix;
        end else if (start && in_item.mode == vibe_pkg::MODE_CLASSIFY) begin
          req.addr = {r_in, c_in, {SlotW{1'b0}}};
        end
      end
      vibe_pkg::ST_READ: req.addr = {r_r, c_r, k_r[SlotW-1:0]};
      vibe_pkg::ST_WR_NB: begin
        req.we = 1'b1;
        req.addr = {nr_r, nc_r, item_r.sample_slot};
        req.wdata = {item_r.chan2, item_r.chan1, item_r.chan0};
      end
      default: req = '0;
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vibe_pkg::ST_IDLE;
      strobe_r <= 1'b0;
      rv_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      strobe_r <= (state_r == vibe_pkg::ST_DONE);
      rv_r <= (state_r == vibe_pkg::ST_IDLE) ? (start && in_item.mode == vibe_pkg::MODE_CLASSIFY)
            : (state_r == vibe_pkg::ST_READ);
    end
    if (state_r == vibe_pkg::ST_IDLE && start) begin
      item_r <= in_item;
      r_r <= r_in; c_r <= c_in; nr_r <= nb_r; nc_r <= nb_c;
      k_r <= (SlotW+1)'(1);
      cnt_r <= '0;
    end else if (state_r == vibe_pkg::ST_READ) begin
      k_r <= k_r + 1'b1;
      cnt_r <= cnt_r + CntW'(close);
    end
    if (state_r == vibe_pkg::ST_DONE) begin
      fg_r <= (item_r.mode == vibe_pkg::MODE_CLASSIFY) && (5'(cnt_r) < min_close);
    end
  end

  assign busy = (state_r != vibe_pkg::ST_IDLE);
  assign out_strobe = strobe_r;
  assign out_item.is_foreground = fg_r;
  assign out_item.close_count = (item_r.mode == vibe_pkg::MODE_CLASSIFY) ? 5'(cnt_r) : 5'd0;
endmodule
`default_nettype wire

/* rtl/core/vibe_background_subtractor_unit.sv */
// Top level of the background subtractor: config registers, sequencer, memory.
// Depends on vibe_pkg, vibe_seq, vibe_sample_mem.
//
// Use: raise start with a beat on in_item while busy is low. Modes: classify
// reads the pixel's 16 samples one per cycle from a single-port memory and
// counts close ones; update, when update_draw is zero and mask_foreground is
// low, writes the pixel and a clamped neighbour; init writes one sample with
// a noise offset. Exactly one result beat per item appears on out_item with
// out_strobe high for one cycle. Classify passes through ST_READ, reading
// one sample per cycle over the single memory port, then ST_DONE; an update
// that writes passes through ST_WR_NB then ST_DONE; other items go straight
// to ST_DONE. The result beat is registered from ST_DONE; busy drops in the
// cycle that shows it, so the next item can be accepted at the edge ending it.
// Configuration: write cfg_data to register cfg_index while idle.
// Reset (synchronous, rst_n low) restores register defaults and idles the
// sequencer; sample memory is not cleared and must be initialized by the host.
// The receiver cannot stall: the result beat is shown for one cycle only.
`default_nettype none
module vibe_background_subtractor_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire vibe_pkg::in_item_t in_item,
  output logic                    out_strobe,
  output vibe_pkg::out_item_t     out_item,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [7:0]         cfg_data
);
  logic [7:0] thresh_r, rows_r, cols_r;
  logic [4:0] minc_r;

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= 8'd20; minc_r <= 5'd2; rows_r <= 8'd128; cols_r <= 8'd128;
    end else if (cfg_we) begin
      case (cfg_index)
        vibe_pkg::CfgThresh:   thresh_r <= cfg_data;
        vibe_pkg::CfgMinClose: minc_r <= cfg_data[4:0];
        vibe_pkg::CfgRows:     rows_r <= cfg_data;
        vibe_pkg::CfgCols:     cols_r <= cfg_data;
        default: ;
      endcase
    end
  end

  vibe_pkg::mem_req_t req;
  logic [23:0] rdata;

  vibe_seq u_seq (
    .clk, .rst_n, .start, .in_item,
    .thresh(thresh_r), .min_close(minc_r), .rows(rows_r), .cols(cols_r),
    .rdata, .req, .busy, .out_strobe, .out_item
  );

  vibe_sample_mem u_mem (.clk, .req, .rdata);
endmodule
`default_nettype wire
